@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the texel mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clock, resetn, ante, cons) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that the antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, clock, resetn, ante, cons) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/rcwm_pkg.sv @@
// Types and constants of the wall column texel mapper.
`timescale 1ns / 1ps
`default_nettype none
package rcwm_pkg;

    typedef enum logic [2:0] {
        CFG_SCREEN_WIDTH   = 3'd0,
        CFG_SCREEN_HEIGHT  = 3'd1,
        CFG_TILE_SIZE      = 3'd2,
        CFG_PROJ_DISTANCE  = 3'd3,
        CFG_TEXTURE_WIDTH  = 3'd4,
        CFG_TEXTURE_HEIGHT = 3'd5,
        CFG_CEILING_COLOR  = 3'd6,
        CFG_FLOOR_COLOR    = 3'd7
    } cfg_index_t;

    localparam logic [1:0] KIND_CEILING = 2'd0;
    localparam logic [1:0] KIND_FLOOR   = 2'd1;
    localparam logic [1:0] KIND_WALL    = 2'd2;

    localparam logic [1:0] TEX_NORTH = 2'd0;
    localparam logic [1:0] TEX_SOUTH = 2'd1;
    localparam logic [1:0] TEX_WEST  = 2'd2;
    localparam logic [1:0] TEX_EAST  = 2'd3;

    localparam int HEIGHT_Q_W = 24;
    localparam int TEXEL_Q_W  = 9;

    // Side data carried alongside the height division.
    typedef struct packed {
        logic [11:0] row;
        logic [23:0] frame;
        logic [1:0]  sel;
        logic        sat;
        logic [7:0]  coord_lo;
    } hdiv_tag_t;

    // Side data carried alongside the texel divisions.
    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] frame;
        logic [1:0]  sel;
    } tdiv_tag_t;

endpackage
`default_nettype wire

@@ rtl/rcwm_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none
module rcwm_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int Q_W   = 16,
    parameter int TAG_W = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    input  wire logic [TAG_W-1:0] tag_in,
    output logic                  out_valid,
    output logic [Q_W-1:0]        quo,
    output logic [NUM_W-1:0]      rem,
    output logic [TAG_W-1:0]      tag_out
);

    logic [NUM_W-1:0] rem_in   [Q_W];
    logic [Q_W-1:0]   quo_in   [Q_W];
    logic [NUM_W-1:0] den_in   [Q_W];
    logic [TAG_W-1:0] tag_s_in [Q_W];
    logic             vld_in   [Q_W];

    logic [NUM_W-1:0] rem_next [Q_W];
    logic [Q_W-1:0]   quo_next [Q_W];
    logic [NUM_W-1:0] rem_reg  [Q_W];
    logic [Q_W-1:0]   quo_reg  [Q_W];
    logic [NUM_W-1:0] den_reg  [Q_W];
    logic [TAG_W-1:0] tag_reg  [Q_W];
    logic             vld_reg  [Q_W];

    assign rem_in[0]   = num;
    assign quo_in[0]   = '0;
    assign den_in[0]   = NUM_W'(den);
    assign tag_s_in[0] = tag_in;
    assign vld_in[0]   = in_valid;

    genvar i;
    generate
        for (i = 0; i < Q_W; i++)
        begin : g_step
            localparam int B = Q_W - 1 - i;

            if (i > 0)
            begin : g_link
                assign rem_in[i]   = rem_reg[i-1];
                assign quo_in[i]   = quo_reg[i-1];
                assign den_in[i]   = den_reg[i-1];
                assign tag_s_in[i] = tag_reg[i-1];
                assign vld_in[i]   = vld_reg[i-1];
            end

            always_comb
            begin
                rem_next[i] = rem_in[i];
                quo_next[i] = quo_in[i];
                if ((rem_in[i] >> B) >= den_in[i])
                begin
                    rem_next[i]    = rem_in[i] - (den_in[i] << B);
                    quo_next[i][B] = 1'b1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i] <= 1'b0;
                else
                    vld_reg[i] <= vld_in[i];
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
                den_reg[i] <= den_in[i];
                tag_reg[i] <= tag_s_in[i];
            end
        end
    endgenerate

    assign out_valid = vld_reg[Q_W-1];
    assign quo       = quo_reg[Q_W-1];
    assign rem       = rem_reg[Q_W-1];
    assign tag_out   = tag_reg[Q_W-1];

endmodule
`default_nettype wire

@@ rtl/raycast_wall_column_texel_mapper.sv @@
// Top level of the ray-cast wall column texel mapper.
// One pixel is taken in every clock cycle (busy stays low). Its result is on the result
// ports, strobed by result_valid for one cycle; the receiver cannot stall. A pixel passes
// through the 24-step strip height divider and then the 9-step texel row and column
// dividers, each a pipelined one-bit-per-stage unit, plus six further register stages.
// Configuration writes are to be made only while no pixel is in flight; the block itself
// does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module raycast_wall_column_texel_mapper #(
    parameter int MAX_SCREEN_DIM  = 4096,
    parameter int MAX_TEXTURE_DIM = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [11:0] column,
    input  wire logic [11:0] row,
    input  wire logic [23:0] ray_distance,
    input  wire logic [15:0] cos_correction,
    input  wire logic        hit_vertical,
    input  wire logic        facing_up,
    input  wire logic        facing_down,
    input  wire logic        facing_left,
    input  wire logic        facing_right,
    input  wire logic [23:0] hit_x,
    input  wire logic [23:0] hit_y,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    output logic             result_valid,
    output logic [1:0]       pixel_kind,
    output logic [23:0]      fill_color,
    output logic [1:0]       texture_select,
    output logic [15:0]      texel_address,
    output logic [23:0]      frame_address
);

    import rcwm_pkg::*;

    localparam int LATENCY = 6 + HEIGHT_Q_W + TEXEL_Q_W;
    localparam int HTAG_W  = $bits(hdiv_tag_t);
    localparam int TTAG_W  = $bits(tdiv_tag_t);

    // Configuration registers.
    logic [12:0] scr_w_reg, scr_h_reg;
    logic [10:0] tile_reg;
    logic [23:0] proj_reg;
    logic [8:0]  tex_w_reg, tex_h_reg;
    logic [23:0] ceil_reg, floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= 13'd640;
            scr_h_reg <= 13'd480;
            tile_reg  <= 11'd64;
            proj_reg  <= 24'd141890;
            tex_w_reg <= 9'd64;
            tex_h_reg <= 9'd64;
            ceil_reg  <= 24'd0;
            floor_reg <= 24'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:   scr_w_reg <= cfg_data[12:0];
                CFG_SCREEN_HEIGHT:  scr_h_reg <= cfg_data[12:0];
                CFG_TILE_SIZE:      tile_reg  <= cfg_data[10:0];
                CFG_PROJ_DISTANCE:  proj_reg  <= cfg_data;
                CFG_TEXTURE_WIDTH:  tex_w_reg <= cfg_data[8:0];
                CFG_TEXTURE_HEIGHT: tex_h_reg <= cfg_data[8:0];
                CFG_CEILING_COLOR:  ceil_reg  <= cfg_data;
                CFG_FLOOR_COLOR:    floor_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped configuration values.
    logic [12:0] sw_c, sh_c;
    logic [10:0] tile_c;
    logic [8:0]  tw_c, th_c;
    logic [34:0] num_reg;

    always_comb
    begin
        sw_c = (14'(scr_w_reg) > 14'(MAX_SCREEN_DIM)) ? 13'(MAX_SCREEN_DIM) : scr_w_reg;
        sh_c = (14'(scr_h_reg) > 14'(MAX_SCREEN_DIM)) ? 13'(MAX_SCREEN_DIM) : scr_h_reg;
        tile_c = (tile_reg == 11'd0) ? 11'd1 : tile_reg;
        if (tex_w_reg == 9'd0)
            tw_c = 9'd1;
        else if (11'(tex_w_reg) > 11'(MAX_TEXTURE_DIM))
            tw_c = 9'(MAX_TEXTURE_DIM);
        else
            tw_c = tex_w_reg;
        if (tex_h_reg == 9'd0)
            th_c = 9'd1;
        else if (11'(tex_h_reg) > 11'(MAX_TEXTURE_DIM))
            th_c = 9'(MAX_TEXTURE_DIM);
        else
            th_c = tex_h_reg;
    end

    always_ff @(posedge clk)
    begin
        num_reg <= 35'(tile_c) * 35'(proj_reg);
    end

    // Stage 1: input capture.
    logic        v1_reg;
    logic [11:0] col1_reg, row1_reg;
    logic [23:0] dist1_reg, hx1_reg, hy1_reg;
    logic [15:0] cos1_reg;
    logic        vert1_reg, up1_reg, down1_reg, left1_reg, right1_reg;

    always_ff @(posedge clk)
    begin
        col1_reg   <= column;
        row1_reg   <= row;
        dist1_reg  <= ray_distance;
        cos1_reg   <= cos_correction;
        vert1_reg  <= hit_vertical;
        up1_reg    <= facing_up;
        down1_reg  <= facing_down;
        left1_reg  <= facing_left;
        right1_reg <= facing_right;
        hx1_reg    <= hit_x;
        hy1_reg    <= hit_y;
    end

    // Stage 2: corrected distance, frame address, texture choice.
    logic        v2_reg;
    logic [11:0] row2_reg;
    logic [23:0] frame2_reg, coord2_reg;
    logic [24:0] corr2_reg;
    logic [1:0]  sel2_reg;
    logic [1:0]  sel_next;

    always_comb
    begin
        if (up1_reg && !vert1_reg)
            sel_next = TEX_NORTH;
        else if (down1_reg && !vert1_reg)
            sel_next = TEX_SOUTH;
        else if (left1_reg && vert1_reg)
            sel_next = TEX_WEST;
        else if (right1_reg && vert1_reg)
            sel_next = TEX_EAST;
        else
            sel_next = TEX_NORTH;
    end

    always_ff @(posedge clk)
    begin
        row2_reg   <= row1_reg;
        corr2_reg  <= 25'((40'(dist1_reg) * 40'(cos1_reg)) >> 15);
        frame2_reg <= 24'(25'(row1_reg) * 25'(sw_c) + 25'(col1_reg));
        coord2_reg <= vert1_reg ? hy1_reg : hx1_reg;
        sel2_reg   <= sel_next;
    end

    // Stage 3: saturation check ahead of the height division.
    logic        v3_reg;
    logic [24:0] corr3_reg;
    hdiv_tag_t   htag3_reg;

    always_ff @(posedge clk)
    begin
        corr3_reg          <= corr2_reg;
        htag3_reg.row      <= row2_reg;
        htag3_reg.frame    <= frame2_reg;
        htag3_reg.sel      <= sel2_reg;
        htag3_reg.coord_lo <= coord2_reg[7:0];
        htag3_reg.sat      <= (corr2_reg == 25'd0) ||
                              (49'(num_reg) >= {corr2_reg, 24'd0});
    end

    logic [23:0] coord3_hi_reg;
    always_ff @(posedge clk)
    begin
        coord3_hi_reg <= coord2_reg;
    end

    // Strip height and texel column remainder dividers run in lockstep.
    logic                  hd_valid;
    logic [HEIGHT_Q_W-1:0] hd_quo;
    logic [HTAG_W-1:0]     hd_tag_bits;
    logic [15:0]           cd_rem;
    hdiv_tag_t             hd_tag;

    rcwm_div #(
        .NUM_W (35),
        .DEN_W (25),
        .Q_W   (HEIGHT_Q_W),
        .TAG_W (HTAG_W)
    ) u_height_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       (num_reg),
        .den       (corr3_reg),
        .tag_in    (htag3_reg),
        .out_valid (hd_valid),
        .quo       (hd_quo),
        .rem       (),
        .tag_out   (hd_tag_bits)
    );

    // Remainder of (coord >> 8) by the tile size gives the coordinate within its tile.
    rcwm_div #(
        .NUM_W (16),
        .DEN_W (11),
        .Q_W   (HEIGHT_Q_W),
        .TAG_W (1)
    ) u_tile_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       (coord3_hi_reg[23:8]),
        .den       (tile_c),
        .tag_in    (1'b0),
        .out_valid (),
        .quo       (),
        .rem       (cd_rem),
        .tag_out   ()
    );

    assign hd_tag = hdiv_tag_t'(hd_tag_bits);

    // Stage 4: strip extent and pixel classification.
    logic [23:0] h_c, top_c, bot_raw_c, bot_c, dft_c;
    logic [22:0] half_h_c;
    logic [11:0] half_s_c;
    logic        wall_c;
    logic [1:0]  kind_c;

    always_comb
    begin
        h_c       = hd_tag.sat ? 24'hFFFFFF : hd_quo[23:0];
        half_h_c  = h_c[23:1];
        half_s_c  = sh_c[12:1];
        top_c     = (24'(half_s_c) > 24'(half_h_c)) ? 24'(half_s_c) - 24'(half_h_c) : 24'd0;
        bot_raw_c = 24'(half_s_c) + 24'(half_h_c);
        bot_c     = (bot_raw_c > 24'(sh_c)) ? 24'(sh_c) : bot_raw_c;
        wall_c    = (24'(hd_tag.row) >= top_c) && (24'(hd_tag.row) < bot_c);
        dft_c     = 24'(25'(hd_tag.row) + 25'(half_h_c) - 25'(half_s_c));
        if (wall_c)
            kind_c = KIND_WALL;
        else if (hd_tag.row < half_s_c)
            kind_c = KIND_CEILING;
        else
            kind_c = KIND_FLOOR;
    end

    logic        v4_reg;
    logic [23:0] h4_reg, dft4_reg;
    logic [18:0] r4_reg;
    tdiv_tag_t   ttag4_reg;

    always_ff @(posedge clk)
    begin
        h4_reg          <= h_c;
        dft4_reg        <= dft_c;
        r4_reg          <= {cd_rem[10:0], hd_tag.coord_lo};
        ttag4_reg.kind  <= kind_c;
        ttag4_reg.frame <= hd_tag.frame;
        ttag4_reg.sel   <= hd_tag.sel;
    end

    // Stage 5: numerators of the texel row and column.
    logic        v5_reg;
    logic [23:0] h5_reg;
    logic [32:0] rnum5_reg;
    logic [27:0] cnum5_reg;
    tdiv_tag_t   ttag5_reg;

    always_ff @(posedge clk)
    begin
        h5_reg    <= h4_reg;
        rnum5_reg <= 33'(dft4_reg) * 33'(th_c);
        cnum5_reg <= 28'(r4_reg) * 28'(tw_c);
        ttag5_reg <= ttag4_reg;
    end

    logic                 td_valid;
    logic [TEXEL_Q_W-1:0] trow_q, tcol_q;
    logic [TTAG_W-1:0]    td_tag_bits;
    tdiv_tag_t            td_tag;

    rcwm_div #(
        .NUM_W (33),
        .DEN_W (24),
        .Q_W   (TEXEL_Q_W),
        .TAG_W (TTAG_W)
    ) u_row_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .num       (rnum5_reg),
        .den       (h5_reg),
        .tag_in    (ttag5_reg),
        .out_valid (td_valid),
        .quo       (trow_q),
        .rem       (),
        .tag_out   (td_tag_bits)
    );

    rcwm_div #(
        .NUM_W (28),
        .DEN_W (19),
        .Q_W   (TEXEL_Q_W),
        .TAG_W (1)
    ) u_col_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .num       (cnum5_reg),
        .den       ({tile_c, 8'd0}),
        .tag_in    (1'b0),
        .out_valid (),
        .quo       (tcol_q),
        .rem       (),
        .tag_out   ()
    );

    assign td_tag = tdiv_tag_t'(td_tag_bits);

    // Output stage.
    logic        out_v_reg;
    logic [1:0]  kind_reg, sel_reg;
    logic [23:0] fill_reg, frame_reg;
    logic [15:0] taddr_reg;
    logic [18:0] taddr_c;

    assign taddr_c = 19'(18'(trow_q) * 18'(tw_c)) + 19'(tcol_q);

    always_ff @(posedge clk)
    begin
        kind_reg  <= td_tag.kind;
        frame_reg <= td_tag.frame;
        case (td_tag.kind)
            KIND_WALL:
            begin
                fill_reg  <= 24'd0;
                sel_reg   <= td_tag.sel;
                taddr_reg <= taddr_c[15:0];
            end
            KIND_CEILING:
            begin
                fill_reg  <= ceil_reg;
                sel_reg   <= TEX_NORTH;
                taddr_reg <= 16'd0;
            end
            default:
            begin
                fill_reg  <= floor_reg;
                sel_reg   <= TEX_NORTH;
                taddr_reg <= 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= start && !busy;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= hd_valid;
            v5_reg    <= v4_reg;
            out_v_reg <= td_valid;
        end
    end

    assign busy           = 1'b0;
    assign result_valid   = out_v_reg;
    assign pixel_kind     = kind_reg;
    assign fill_color     = fill_reg;
    assign texture_select = sel_reg;
    assign texel_address  = taddr_reg;
    assign frame_address  = frame_reg;

    `ASSERT_IMPLY(a_latency, clk, rst_n, start && !busy, ##LATENCY result_valid)
    `ASSERT_IMPLY(a_no_spurious, clk, rst_n, result_valid, $past(start, LATENCY))
    `ASSERT_IMPLY(a_bg_no_texel, clk, rst_n, result_valid && pixel_kind != KIND_WALL,
                  texel_address == 16'd0 && texture_select == TEX_NORTH)
    `ASSERT_NEXT(a_wall_no_fill, clk, rst_n, td_valid && td_tag.kind == KIND_WALL,
                 fill_color == 24'd0)

endmodule
`default_nettype wire
